// ===== hw/rtl/bfr_pkg.sv =====
// Shared types and constants of the blob frame receiver.
package bfr_pkg;

  // Sync pair that opens every frame.
  localparam logic [7:0] SYNC_FIRST  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND = 8'h55;

  // Byte positions within the 21-byte frame.
  localparam int unsigned POS_W = 5;
  localparam logic [POS_W-1:0] POS_HUNT      = 5'd0;
  localparam logic [POS_W-1:0] POS_SECOND    = 5'd1;
  localparam logic [POS_W-1:0] POS_TYPE      = 5'd2;
  localparam logic [POS_W-1:0] POS_COLOR     = 5'd3;
  localparam logic [POS_W-1:0] POS_FIELDS    = 5'd4;
  localparam logic [POS_W-1:0] POS_CHECKSUM  = 5'd20;

  // Bytes 4..19 carry the result fields.
  localparam int unsigned FIELD_BYTES = 16;
  localparam int unsigned FIELD_IDX_W = $clog2(FIELD_BYTES);

  // Configuration register reset values.
  localparam logic [7:0] RESET_TYPE  = 8'h11;
  localparam logic [7:0] RESET_COLOR = 8'h42;

  // Default queue depths (powers of two, at least two).
  localparam int unsigned ITEM_QUEUE_DEPTH   = 2;
  localparam int unsigned RESULT_QUEUE_DEPTH = 2;

  // Configuration port.
  localparam int unsigned CFG_INDEX_W = 2;
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_EXPECTED_TYPE  = 2'd0,
    CFG_EXPECTED_COLOR = 2'd1
  } cfg_index_t;

  typedef struct packed {
    logic [7:0] expected_type;
    logic [7:0] expected_color;
  } cfg_t;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_BAD_ID  = 2'd1,
    STATUS_BAD_SUM = 2'd2
  } status_t;

  // A frame byte tagged with its position, passed from front to back.
  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [7:0]       data;
  } frame_item_t;

  // One decoded frame result.
  typedef struct packed {
    status_t     status;
    logic [7:0]  sequence_res;
    logic [7:0]  found;
    logic [15:0] x_error;
    logic [15:0] center_x;
    logic [15:0] center_y;
    logic [15:0] blob_width;
    logic [15:0] blob_height;
    logic [31:0] pixel_count;
  } result_t;

endpackage

// ===== hw/rtl/bfr_queue.sv =====
// Small register-based first-in first-out queue.
module bfr_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_FULL);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

// ===== hw/rtl/bfr_front.sv =====
// Front end: sync hunt and tagging of frame bytes with their position.
module bfr_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [7:0]          rx_byte,
  input  logic                q_full,
  output logic                q_push,
  output bfr_pkg::frame_item_t q_item
);

  logic [bfr_pkg::POS_W-1:0] position;
  logic [bfr_pkg::POS_W-1:0] position_next;
  logic                      accept;

  assign accept = push && !q_full;

  // Frame bytes from the type byte onward go to the back end.
  assign q_push      = accept && (position >= bfr_pkg::POS_TYPE);
  assign q_item.data = rx_byte;
  assign q_item.pos  = (position >= bfr_pkg::POS_CHECKSUM) ? bfr_pkg::POS_CHECKSUM : position;

  // Position tracking through the sync pair and the frame body.
  always_comb begin
    position_next = position;
    if (position == bfr_pkg::POS_HUNT) begin
      if (rx_byte == bfr_pkg::SYNC_FIRST) begin
        position_next = bfr_pkg::POS_SECOND;
      end
    end else if (position == bfr_pkg::POS_SECOND) begin
      if (rx_byte == bfr_pkg::SYNC_SECOND) begin
        position_next = bfr_pkg::POS_TYPE;
      end else if (rx_byte == bfr_pkg::SYNC_FIRST) begin
        position_next = bfr_pkg::POS_SECOND;
      end else begin
        position_next = bfr_pkg::POS_HUNT;
      end
    end else if (position < bfr_pkg::POS_CHECKSUM) begin
      position_next = position + bfr_pkg::POS_W'(1);
    end else begin
      position_next = bfr_pkg::POS_HUNT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= bfr_pkg::POS_HUNT;
    end else if (accept) begin
      position <= position_next;
    end
  end

endmodule

// ===== hw/rtl/bfr_back.sv =====
// Back end: collects frame bytes, checks the frame and builds the result.
module bfr_back (
  input  logic                 clk,
  input  logic                 rst,
  input  bfr_pkg::cfg_t        cfg,
  input  logic                 q_empty,
  input  bfr_pkg::frame_item_t q_item,
  output logic                 q_pop,
  input  logic                 res_full,
  output logic                 res_push,
  output bfr_pkg::result_t     res
);

  logic [7:0]                    field_bytes [bfr_pkg::FIELD_BYTES];
  logic [7:0]                    running_sum;
  logic [7:0]                    type_byte;
  logic [7:0]                    color_byte;
  logic                          is_last;
  logic [bfr_pkg::FIELD_IDX_W-1:0] field_idx;
  bfr_pkg::status_t              status;

  assign is_last   = (q_item.pos == bfr_pkg::POS_CHECKSUM);
  assign q_pop     = !q_empty && (!is_last || !res_full);
  assign res_push  = q_pop && is_last;
  assign field_idx = bfr_pkg::FIELD_IDX_W'(q_item.pos - bfr_pkg::POS_FIELDS);

  // Running sum of the frame body as bytes arrive.
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
    end else if (q_pop && !is_last) begin
      if (q_item.pos == bfr_pkg::POS_TYPE) begin
        running_sum <= q_item.data;
      end else begin
        running_sum <= running_sum + q_item.data;
      end
    end
  end

  // Identity and field bytes are held until the frame completes.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      if (q_item.pos == bfr_pkg::POS_TYPE) begin
        type_byte <= q_item.data;
      end
      if (q_item.pos == bfr_pkg::POS_COLOR) begin
        color_byte <= q_item.data;
      end
      if (q_item.pos >= bfr_pkg::POS_FIELDS && !is_last) begin
        field_bytes[field_idx] <= q_item.data;
      end
    end
  end

  // Status: an identity mismatch wins over a checksum mismatch.
  always_comb begin
    if (type_byte != cfg.expected_type || color_byte != cfg.expected_color) begin
      status = bfr_pkg::STATUS_BAD_ID;
    end else if (running_sum != q_item.data) begin
      status = bfr_pkg::STATUS_BAD_SUM;
    end else begin
      status = bfr_pkg::STATUS_OK;
    end
  end

  // Result fields are little endian and zero unless the frame is good.
  always_comb begin
    res        = '0;
    res.status = status;
    if (status == bfr_pkg::STATUS_OK) begin
      res.sequence_res = field_bytes[0];
      res.found        = field_bytes[1];
      res.x_error      = {field_bytes[3], field_bytes[2]};
      res.center_x     = {field_bytes[5], field_bytes[4]};
      res.center_y     = {field_bytes[7], field_bytes[6]};
      res.blob_width   = {field_bytes[9], field_bytes[8]};
      res.blob_height  = {field_bytes[11], field_bytes[10]};
      res.pixel_count  = {field_bytes[15], field_bytes[14], field_bytes[13], field_bytes[12]};
    end
  end

endmodule

// ===== hw/rtl/blob_frame_receiver.sv =====
// Top level of the blob frame receiver: config registers, front, queues and back.
//
//   channel   direction  handshake              payload
//   input     in         push / full            rx_byte
//   result    out        empty / pop            status .. pixel_count
//   config    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One byte is taken every cycle while full is low. A result reaches the result
// ports through both queues: the checksum byte is registered in the byte
// queue and the back end pushes the result as it takes the byte. Synchronous
// reset clears the sync hunt, both queues and restores the register defaults.
// Input stalls only when the result queue is full and the byte queue has
// filled behind a waiting checksum byte.
module blob_frame_receiver #(
  parameter int unsigned ITEM_DEPTH   = bfr_pkg::ITEM_QUEUE_DEPTH,
  parameter int unsigned RESULT_DEPTH = bfr_pkg::RESULT_QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic [7:0]                      rx_byte,
  output logic                            empty,
  input  logic                            pop,
  output logic [1:0]                      status,
  output logic [7:0]                      sequence_res,
  output logic [7:0]                      found,
  output logic signed [15:0]              x_error,
  output logic [15:0]                     center_x,
  output logic [15:0]                     center_y,
  output logic [15:0]                     blob_width,
  output logic [15:0]                     blob_height,
  output logic [31:0]                     pixel_count,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bfr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]                      cfg_data
);

  localparam int unsigned ITEM_W   = $bits(bfr_pkg::frame_item_t);
  localparam int unsigned RESULT_W = $bits(bfr_pkg::result_t);

  bfr_pkg::cfg_t        cfg;
  bfr_pkg::frame_item_t front_item;
  bfr_pkg::frame_item_t back_item;
  bfr_pkg::result_t     back_res;
  bfr_pkg::result_t     out_res;
  logic                 item_push;
  logic                 item_full;
  logic                 item_pop;
  logic                 item_empty;
  logic [ITEM_W-1:0]    item_dout;
  logic                 res_push;
  logic                 res_full;
  logic [RESULT_W-1:0]  res_dout;

  // Configuration registers; writes to unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.expected_type  <= bfr_pkg::RESET_TYPE;
      cfg.expected_color <= bfr_pkg::RESET_COLOR;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bfr_pkg::CFG_EXPECTED_TYPE:  cfg.expected_type  <= cfg_data;
        bfr_pkg::CFG_EXPECTED_COLOR: cfg.expected_color <= cfg_data;
        default: ;
      endcase
    end
  end

  assign full = item_full;

  bfr_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .rx_byte (rx_byte),
    .q_full  (item_full),
    .q_push  (item_push),
    .q_item  (front_item)
  );

  bfr_queue #(
    .WIDTH (ITEM_W),
    .DEPTH (ITEM_DEPTH)
  ) u_item_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (item_push),
    .din   (front_item),
    .full  (item_full),
    .pop   (item_pop),
    .dout  (item_dout),
    .empty (item_empty)
  );

  assign back_item = bfr_pkg::frame_item_t'(item_dout);

  bfr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_empty  (item_empty),
    .q_item   (back_item),
    .q_pop    (item_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res      (back_res)
  );

  bfr_queue #(
    .WIDTH (RESULT_W),
    .DEPTH (RESULT_DEPTH)
  ) u_result_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (back_res),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_dout),
    .empty (empty)
  );

  // Result ports.
  assign out_res      = bfr_pkg::result_t'(res_dout);
  assign status       = out_res.status;
  assign sequence_res = out_res.sequence_res;
  assign found        = out_res.found;
  assign x_error      = out_res.x_error;
  assign center_x     = out_res.center_x;
  assign center_y     = out_res.center_y;
  assign blob_width   = out_res.blob_width;
  assign blob_height  = out_res.blob_height;
  assign pixel_count  = out_res.pixel_count;

endmodule
